// ===== rtl/fpq_pkg.sv =====
// Shared types, codes and command structures of the request queue.
package fpq_pkg;

  localparam int CFG_W = 5;

  localparam logic CFG_MODE     = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  localparam logic             MODE_FIFO  = 1'b0;
  localparam logic             MODE_PRIO  = 1'b1;
  localparam logic [CFG_W-1:0] CAP_RESET  = 5'd16;

  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic        func;
    logic [15:0] handle;
    logic [3:0]  priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_handle;
    logic [3:0]  out_priority;
  } rsp_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [3:0]  prio;
  } entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_REFUSE_FULL,
    OP_REFUSE_EMPTY,
    OP_FIFO_PUT,
    OP_FIFO_GET,
    OP_FIFO_TAKE,
    OP_PQ_PUT,
    OP_SHIFT_UP,
    OP_PLACE,
    OP_PQ_GET,
    OP_HEAD,
    OP_COMPACT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   publish;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic full;
    logic empty;
    logic shift_go;
    logic count_zero;
    logic compact_last;
  } dp_stat_t;

endpackage

// ===== rtl/fpq_datapath.sv =====
// Datapath of the request queue: entry memory, pointers, fill count and result registers.
module fpq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [fpq_pkg::CFG_W-1:0] cfg_data,
  input  fpq_pkg::req_t            req_data,
  input  fpq_pkg::dp_cmd_t         cmd,
  output fpq_pkg::dp_stat_t        stat,
  output fpq_pkg::rsp_t            rsp_data
);
  import fpq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t            mem [QUEUE_DEPTH];
  entry_t            rdata;
  logic              mode;
  logic [CFG_W-1:0]  cap_raw;
  logic [CW-1:0]     cap_live;
  logic [IW-1:0]     count;
  logic [IW-1:0]     wptr;
  logic [IW-1:0]     rptr;
  logic [IW-1:0]     pos;
  req_t              req;
  rsp_t              res;

  logic              mem_we;
  logic [IW-1:0]     waddr;
  entry_t            wdata;
  logic [IW-1:0]     raddr;
  logic [IW:0]       pos_up1;
  logic [IW:0]       pos_up2;
  logic              wptr_wrap;
  logic              rptr_wrap;
  logic [CW-1:0]     ring_fill;

  // Capacities below two act as two, above the memory depth as the depth.
  always_comb begin
    if (cap_raw < CFG_W'(2)) begin
      cap_live = CW'(2);
    end else if (32'(cap_raw) > QUEUE_DEPTH) begin
      cap_live = CW'(QUEUE_DEPTH);
    end else begin
      cap_live = CW'(cap_raw);
    end
  end

  assign wptr_wrap = (CW'(wptr) + CW'(1)) >= cap_live;
  assign rptr_wrap = (CW'(rptr) + CW'(1)) >= cap_live;
  assign pos_up1   = (IW+1)'(pos) + (IW+1)'(1);
  assign pos_up2   = (IW+1)'(pos) + (IW+1)'(2);

  assign stat.mode         = mode;
  assign stat.full         = (CW'(count) + CW'(1)) >= cap_live;
  assign stat.empty        = (count == '0);
  assign stat.count_zero   = (count == '0);
  assign stat.shift_go     = (pos != '0) && (rdata.prio < req.priority_req);
  assign stat.compact_last = (pos_up1 == (IW+1)'(count));

  // The entry memory read is registered: an entry appears in rdata in the cycle after its read address is issued.
  always_comb begin
    unique case (cmd.op)
      OP_FIFO_GET: raddr = rptr;
      OP_PQ_PUT:   raddr = (count == '0) ? '0 : count - IW'(1);
      OP_SHIFT_UP: raddr = (pos >= IW'(2)) ? pos - IW'(2) : '0;
      OP_HEAD:     raddr = (pos_up1 >= (IW+1)'(QUEUE_DEPTH)) ? '0 : pos_up1[IW-1:0];
      OP_COMPACT:  raddr = (pos_up2 >= (IW+1)'(QUEUE_DEPTH)) ? '0 : pos_up2[IW-1:0];
      default:     raddr = '0;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = pos;
    wdata  = rdata;
    unique case (cmd.op)
      OP_FIFO_PUT: begin
        mem_we = 1'b1;
        waddr  = wptr;
        wdata  = '{handle: req_data.handle, prio: req_data.priority_req};
      end
      OP_SHIFT_UP: begin
        mem_we = 1'b1;
      end
      OP_PLACE: begin
        mem_we = 1'b1;
        wdata  = '{handle: req.handle, prio: req.priority_req};
      end
      OP_COMPACT: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  // Control state: configuration, pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_FIFO;
      cap_raw <= CAP_RESET;
      count   <= '0;
      wptr    <= '0;
      rptr    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) begin
        mode <= cfg_data[0];
      end else begin
        cap_raw <= cfg_data;
      end
      count <= '0;
      wptr  <= '0;
      rptr  <= '0;
    end else begin
      unique case (cmd.op)
        OP_FIFO_PUT: begin
          wptr  <= wptr_wrap ? '0 : wptr + IW'(1);
          count <= count + IW'(1);
        end
        OP_FIFO_GET: begin
          rptr  <= rptr_wrap ? '0 : rptr + IW'(1);
          count <= count - IW'(1);
        end
        OP_PLACE:  count <= count + IW'(1);
        OP_PQ_GET: count <= count - IW'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_REFUSE_FULL:  res <= '{status: ST_FULL, out_handle: '0, out_priority: '0};
      OP_REFUSE_EMPTY: res <= '{status: ST_EMPTY, out_handle: '0, out_priority: '0};
      OP_FIFO_PUT:     res <= '{status: ST_DONE, out_handle: '0, out_priority: '0};
      OP_PLACE:        res <= '{status: ST_DONE, out_handle: '0, out_priority: '0};
      OP_FIFO_TAKE:    res <= '{status: ST_DONE, out_handle: rdata.handle,
                                out_priority: rdata.prio};
      OP_HEAD:         res <= '{status: ST_DONE, out_handle: rdata.handle,
                                out_priority: rdata.prio};
      default: begin
      end
    endcase
    unique case (cmd.op)
      OP_PQ_PUT: begin
        req <= req_data;
        pos <= count;
      end
      OP_SHIFT_UP: pos <= pos - IW'(1);
      OP_PQ_GET:   pos <= '0;
      OP_COMPACT:  pos <= pos_up1[IW-1:0];
      default: begin
      end
    endcase
    if (cmd.publish) begin
      rsp_data <= res;
    end
  end

  // Distance from read to write pointer around the ring.
  always_comb begin
    if (wptr >= rptr) begin
      ring_fill = CW'(wptr) - CW'(rptr);
    end else begin
      ring_fill = CW'(wptr) + cap_live - CW'(rptr);
    end
  end

  a_count_below_cap: assert property (@(posedge clk) disable iff (rst)
    CW'(count) < cap_live)
    else $error("fill count reached the live capacity");

  a_ring_matches_count: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_FIFO) |-> (ring_fill == CW'(count)))
    else $error("ring pointers disagree with fill count");

  a_prio_ptrs_idle: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_PRIO) |-> (wptr == '0 && rptr == '0))
    else $error("ring pointers moved in priority mode");

endmodule

// ===== rtl/fpq_ctrl.sv =====
// Controller state machine of the request queue: sequences datapath commands per request.
module fpq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_func,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  fpq_pkg::dp_stat_t stat,
  output fpq_pkg::dp_cmd_t  cmd
);
  import fpq_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    FIFO_TAKE,
    INSERT,
    HEAD,
    COMPACT,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   publish;

  assign req_stall = (state != IDLE);
  assign publish   = (state == FINISH) && (!rsp_valid || !rsp_stall);

  always_comb begin
    cmd.op      = OP_NONE;
    cmd.publish = publish;
    state_next  = state;
    unique case (state)
      IDLE: begin
        if (req_valid) begin
          priority if (req_func == FUNC_PUT && stat.full) begin
            cmd.op     = OP_REFUSE_FULL;
            state_next = FINISH;
          end else if (req_func == FUNC_GET && stat.empty) begin
            cmd.op     = OP_REFUSE_EMPTY;
            state_next = FINISH;
          end else if (req_func == FUNC_PUT && stat.mode == MODE_FIFO) begin
            cmd.op     = OP_FIFO_PUT;
            state_next = FINISH;
          end else if (req_func == FUNC_PUT) begin
            cmd.op     = OP_PQ_PUT;
            state_next = INSERT;
          end else if (stat.mode == MODE_FIFO) begin
            cmd.op     = OP_FIFO_GET;
            state_next = FIFO_TAKE;
          end else begin
            cmd.op     = OP_PQ_GET;
            state_next = HEAD;
          end
        end
      end
      FIFO_TAKE: begin
        cmd.op     = OP_FIFO_TAKE;
        state_next = FINISH;
      end
      INSERT: begin
        if (stat.shift_go) begin
          cmd.op = OP_SHIFT_UP;
        end else begin
          cmd.op     = OP_PLACE;
          state_next = FINISH;
        end
      end
      HEAD: begin
        cmd.op     = OP_HEAD;
        state_next = stat.count_zero ? FINISH : COMPACT;
      end
      COMPACT: begin
        cmd.op = OP_COMPACT;
        if (stat.compact_last) begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (publish) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (publish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/fifo_or_priority_request_queue_unit.sv =====
// Top level of the dual-mode request queue: controller plus datapath.
// A queue of (handle, priority) entries that runs either as a first-in first-out
// ring or as a list kept sorted by descending priority, where equal priorities
// leave in arrival order. Every request yields exactly one response: status
// done, put refused because the queue is full, or get refused because it is
// empty. At most capacity minus one entries are held, and a write of either
// configuration register empties the queue. Requests are handled one at a
// time, and the request port stalls until the response has been registered.
// In priority mode a put moves each held entry of lower priority back by one
// slot before placing the new entry, and a get moves each entry left in the
// queue forward by one slot after taking the head, since the single-port entry
// memory moves one entry per cycle. A waiting response holds the unit in its
// final state until the response output is free. No clearing pass is
// needed after reset; entries are only read after they have been written.
module fifo_or_priority_request_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  fpq_pkg::req_t             req_data,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output fpq_pkg::rsp_t             rsp_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [fpq_pkg::CFG_W-1:0] cfg_data
);
  import fpq_pkg::*;

  // Commands flow from the controller to the datapath; status flows back.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  fpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req_data.func),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the entry memory, the configuration registers and the
  // response register that drives the output payload.
  fpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_data  (req_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_data  (rsp_data)
  );

endmodule

// ===== dv/tb_fifo_or_priority_request_queue_unit.sv =====
// Self-checking testbench of the dual-mode request queue: directed table, then random phases.
module tb_fifo_or_priority_request_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fpq_pkg::*;

  localparam int QUEUE_DEPTH   = 16;
  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 10;
  localparam int DIR_ROWS      = 28;
  localparam int RANDOM_REQS   = 1325;
  // The last stretch of the random part runs with no idling on either side.
  localparam int CALM_REQS     = 200;
  // Index of the random request at which the long response hold-off starts.
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 250;
  // Cycles left to the unit after the last response before a register write.
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_REPORTS   = 10;
  // Far above the slowest correct run, with a clock period of 4 ns.
  localparam int TIMEOUT_NS    = 2_000_000;

  // One row of the directed table: either a register write or a request.
  // Where known is set, the response is typed into the row; otherwise the
  // queue model below supplies it.
  typedef struct packed {
    logic             is_cfg;
    logic             cfg_idx;
    logic [CFG_W-1:0] cfg_val;
    req_t             rq;
    logic             known;
    rsp_t             want;
  } dir_row_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req_data  = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp_data;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = CFG_MODE;
  logic [CFG_W-1:0] cfg_data  = '0;

  // Model of the queue: register copies and the entry store.
  logic             q_mode    = MODE_FIFO;
  logic [CFG_W-1:0] q_cap_reg = CAP_RESET;
  entry_t           q_slot [QUEUE_DEPTH];
  int               q_wr      = 0;
  int               q_rd      = 0;
  int               q_held    = 0;

  // Responses predicted for accepted requests, oldest first.
  rsp_t due_rsp [$];
  int   mismatches  = 0;

  logic jitter_on    = 1'b1;
  logic hold_trigger = 1'b0;
  logic long_hold    = 1'b0;
  int   stall_left   = 0;

  always #(CLK_HALF) clk = ~clk;

  fifo_or_priority_request_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Applies one request to the queue model and returns the response it gives.
  // The usable ring size is the capacity register clamped to 2..QUEUE_DEPTH,
  // and one slot always stays free. In priority mode a put walks back past
  // every entry of strictly lower priority, so equal priorities keep their
  // arrival order; a get takes the head and moves the rest forward.
  function automatic rsp_t apply_request(req_t rq);
    rsp_t   res;
    entry_t ent;
    int     lim;
    int     pos;
    int     w;
    lim = int'(q_cap_reg);
    if (lim < 2) lim = 2;
    if (lim > QUEUE_DEPTH) lim = QUEUE_DEPTH;
    res = '{status: ST_DONE, out_handle: '0, out_priority: '0};
    ent = '{handle: rq.handle, prio: rq.priority_req};
    if (rq.func == FUNC_PUT) begin
      if (q_held >= lim - 1) begin
        res.status = ST_FULL;
      end else if (q_mode == MODE_FIFO) begin
        w = q_wr % lim;
        q_slot[w] = ent;
        q_wr = (w + 1 >= lim) ? 0 : w + 1;
        q_held++;
      end else begin
        pos = q_held;
        while (pos > 0 && q_slot[pos-1].prio < ent.prio) begin
          q_slot[pos] = q_slot[pos-1];
          pos--;
        end
        q_slot[pos] = ent;
        q_held++;
        q_wr = q_held;
        q_rd = 0;
      end
    end else if (q_held == 0) begin
      res.status = ST_EMPTY;
    end else if (q_mode == MODE_FIFO) begin
      w = q_rd % lim;
      res.out_handle   = q_slot[w].handle;
      res.out_priority = q_slot[w].prio;
      q_rd = (w + 1 >= lim) ? 0 : w + 1;
      q_held--;
    end else begin
      res.out_handle   = q_slot[0].handle;
      res.out_priority = q_slot[0].prio;
      for (int i = 0; i + 1 < q_held; i++) q_slot[i] = q_slot[i+1];
      q_held--;
      q_wr = q_held;
      q_rd = 0;
    end
    return res;
  endfunction

  function automatic dir_row_t req_row(logic fn, logic [15:0] h, logic [3:0] p,
                                       logic known = 1'b0, logic [1:0] st = ST_DONE,
                                       logic [15:0] oh = '0, logic [3:0] op = '0);
    dir_row_t r;
    r = '0;
    r.rq    = '{func: fn, handle: h, priority_req: p};
    r.known = known;
    r.want  = '{status: st, out_handle: oh, out_priority: op};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic idx, logic [CFG_W-1:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  // Register writes happen only with the unit idle: the request side is
  // lowered, every predicted response has to come back, and a settling wait
  // lets the unit leave its final state. A write of either register
  // empties the queue, so the model is cleared as well.
  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    req_valid <= 1'b0;
    while (due_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) q_mode = val[0];
    else q_cap_reg = val;
    q_wr   = 0;
    q_rd   = 0;
    q_held = 0;
  endtask

  // Offers one request, now and then after a short idle burst, and holds it
  // until the unit takes it. Values read right after the edge are the ones
  // the unit saw at that edge, so the request is accepted exactly when the
  // loop exits. The model is advanced at that same edge.
  task automatic send_request(req_t rq, logic known, rsp_t want);
    rsp_t predicted;
    if (jitter_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= rq;
    do @(posedge clk); while (req_stall);
    predicted = apply_request(rq);
    due_rsp.push_back(known ? want : predicted);
  endtask

  // Response side: checks every accepted response against the oldest
  // prediction and decides the stall for the next cycle. Random stall bursts
  // are added while jitter is on, and the long hold-off process can force the
  // stall on for a whole stretch.
  always @(posedge clk) begin : rsp_side
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: response with none pending: status %0d handle %h prio %0d",
                     $realtime, rsp_data.status, rsp_data.out_handle,
                     rsp_data.out_priority);
        end else begin
          want = due_rsp.pop_front();
          if (rsp_data.status !== want.status ||
              rsp_data.out_handle !== want.out_handle ||
              rsp_data.out_priority !== want.out_priority) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: response mismatch: expected status %0d handle %h prio %0d, %s",
                       $realtime, want.status, want.out_handle, want.out_priority,
                       $sformatf("got status %0d handle %h prio %0d", rsp_data.status,
                                 rsp_data.out_handle, rsp_data.out_priority));
          end
        end
      end
      if (stall_left == 0 && jitter_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 9);
      rsp_stall <= long_hold || (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Long hold-off of the response side. The request side keeps offering
  // requests meanwhile, so the unit fills with a waiting response and has to
  // stall its request port for the whole stretch.
  initial begin
    wait (hold_trigger);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    dir_row_t         dir_tab [DIR_ROWS];
    req_t             rq;
    int               sent;
    int               phase;
    int               phase_len;
    int               burst_left;
    int               put_pct;
    int               pick;
    logic             phase_jitter;
    logic             mode_pick;
    logic [CFG_W-1:0] cap_pick;

    // Directed part. It opens in the reset setting (ring, capacity 16): a get
    // from the empty queue, the field extremes, and priorities outside 1..10.
    // A capacity of 0 must act as 2, so a second put is refused. Priority
    // mode with capacity 31 (acts as 16) checks ordering, including equal
    // priorities leaving in arrival order and raw values 0 and 15. The last
    // write lands while an entry is held, so the queue must come back empty,
    // and capacity 1 must act as 2.
    dir_tab = '{
      req_row(FUNC_GET, 16'h0000, 4'h0, 1'b1, ST_EMPTY),
      req_row(FUNC_PUT, 16'h0000, 4'h0, 1'b1, ST_DONE),
      req_row(FUNC_PUT, 16'hFFFF, 4'hF, 1'b1, ST_DONE),
      req_row(FUNC_GET, 16'hFFFF, 4'hF, 1'b1, ST_DONE, 16'h0000, 4'h0),
      req_row(FUNC_GET, 16'h0000, 4'h0, 1'b1, ST_DONE, 16'hFFFF, 4'hF),
      req_row(FUNC_GET, 16'h0000, 4'h0, 1'b1, ST_EMPTY),
      cfg_row(CFG_CAPACITY, 5'd0),
      req_row(FUNC_PUT, 16'hA5A5, 4'd1, 1'b1, ST_DONE),
      req_row(FUNC_PUT, 16'h5A5A, 4'd10, 1'b1, ST_FULL),
      req_row(FUNC_GET, 16'h0000, 4'h0, 1'b1, ST_DONE, 16'hA5A5, 4'd1),
      cfg_row(CFG_MODE, {4'b0000, MODE_PRIO}),
      cfg_row(CFG_CAPACITY, 5'd31),
      req_row(FUNC_PUT, 16'h1111, 4'd3),
      req_row(FUNC_PUT, 16'h2222, 4'd9),
      req_row(FUNC_PUT, 16'h3333, 4'd3),
      req_row(FUNC_PUT, 16'h4444, 4'd10),
      req_row(FUNC_PUT, 16'h5555, 4'd0),
      req_row(FUNC_PUT, 16'h6666, 4'd15),
      req_row(FUNC_GET, 16'hFFFF, 4'hF),
      req_row(FUNC_GET, 16'h0000, 4'h0),
      req_row(FUNC_GET, 16'h0000, 4'h0),
      req_row(FUNC_GET, 16'h0000, 4'h0),
      req_row(FUNC_GET, 16'h0000, 4'h0),
      cfg_row(CFG_CAPACITY, 5'd1),
      req_row(FUNC_GET, 16'h0000, 4'h0, 1'b1, ST_EMPTY),
      req_row(FUNC_PUT, 16'h0F0F, 4'd5, 1'b1, ST_DONE),
      req_row(FUNC_PUT, 16'hF0F0, 4'd12, 1'b1, ST_FULL),
      req_row(FUNC_GET, 16'h0000, 4'h0, 1'b1, ST_DONE, 16'h0F0F, 4'd5)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].cfg_idx, dir_tab[i].cfg_val);
      else send_request(dir_tab[i].rq, dir_tab[i].known, dir_tab[i].want);
    end

    // Random part, in phases. Each phase starts from an empty queue under a
    // new setting; the first four pin the extremes, later ones draw often
    // from the out-of-range capacities. Within a phase the mix of puts and
    // gets shifts in bursts, so the queue swings between full and empty and
    // both refusals come up often.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_REQS) begin
      case (phase)
        0: begin mode_pick = MODE_FIFO; cap_pick = 5'd16; end
        1: begin mode_pick = MODE_PRIO; cap_pick = 5'd16; end
        2: begin mode_pick = MODE_FIFO; cap_pick = 5'd2;  end
        3: begin mode_pick = MODE_PRIO; cap_pick = 5'd31; end
        default: begin
          mode_pick = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 9))
            0: cap_pick = 5'd0;
            1: cap_pick = 5'd1;
            2: cap_pick = 5'd2;
            3: cap_pick = 5'd16;
            4: cap_pick = 5'd17;
            5: cap_pick = 5'd31;
            default: cap_pick = 5'($urandom_range(2, 16));
          endcase
        end
      endcase
      // Only bit 0 of the mode register counts; the upper data bits are noise.
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_MODE, {4'($urandom_range(0, 15)), mode_pick});
        write_reg(CFG_CAPACITY, cap_pick);
      end else begin
        write_reg(CFG_CAPACITY, cap_pick);
        write_reg(CFG_MODE, {4'($urandom_range(0, 15)), mode_pick});
      end
      phase_jitter = ($urandom_range(0, 3) != 0);
      phase_len    = $urandom_range(40, 160);
      burst_left   = 0;
      put_pct      = 50;
      for (int k = 0; k < phase_len && sent < RANDOM_REQS; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(4, 40);
          case ($urandom_range(0, 2))
            0: put_pct = 15;
            1: put_pct = 50;
            default: put_pct = 85;
          endcase
        end
        burst_left--;
        rq.func   = ($urandom_range(0, 99) < put_pct) ? FUNC_PUT : FUNC_GET;
        rq.handle = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 80) rq.priority_req = 4'($urandom_range(1, 10));
        else if (pick < 90) rq.priority_req = 4'd0;
        else rq.priority_req = 4'($urandom_range(11, 15));
        jitter_on <= phase_jitter && (sent < RANDOM_REQS - CALM_REQS);
        if (sent == HOLD_AT) hold_trigger <= 1'b1;
        send_request(rq, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    req_valid <= 1'b0;
    while (due_rsp.size() != 0) @(posedge clk);
    // A further drain wait catches any response that should not exist.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
